/* hdl/interval_union_coverage_macros.svh */
// assertion macros for the interval union coverage block
// used by interval_union_coverage.sv, expects clk_i and rst_ni in scope
`ifndef INTERVAL_UNION_COVERAGE_MACROS_SVH
`define INTERVAL_UNION_COVERAGE_MACROS_SVH
`ifndef SYNTHESIS
`define IUC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define IUC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `IUC_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define IUC_ASSERT(lbl, prop, msg)
`define IUC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/iuc_pkg.sv */
// shared types and constants of the interval union coverage block
// no dependencies
package iuc_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned ID_W = 64;
  localparam int unsigned CNT_W = ID_W + 1;
  localparam int unsigned DRAIN_CYCLES = 3;
  localparam int unsigned DRAIN_W = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [ID_W-1:0]  id_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_SPAN,
    S_DIFF,
    S_RESULT
  } state_e;

  typedef struct packed {
    id_t range_low;
    id_t range_high;
  } in_word_t;

  typedef struct packed {
    id_t     newly_covered;
    id_t     total_covered;
    status_e insert_status;
  } out_word_t;

  // one table entry as held in the ram
  typedef struct packed {
    id_t lo;
    id_t hi;
  } entry_t;

  // slot read issued by the scan sequencer
  typedef struct packed {
    logic act;
    logic vld;
    idx_t idx;
  } issue_t;

  // merge results back to the sequencer
  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    logic found;
    idx_t abs_idx;
    id_t  new_lo;
    id_t  new_hi;
    cnt_t abs_sum;
  } merge_t;

endpackage

/* hdl/iuc_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module iuc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/iuc_merge.sv */
// per-slot overlap test, bound merge and absorbed size accumulation
// depends on iuc_pkg
module iuc_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              init_i,
  input  iuc_pkg::in_word_t item_i,
  input  iuc_pkg::issue_t   issue_i,
  input  iuc_pkg::entry_t   rd_data_i,
  output iuc_pkg::merge_t   merge_o
);

  iuc_pkg::issue_t p0_q;
  iuc_pkg::cnt_t   hi_p1_q;
  iuc_pkg::id_t    lo_m1_q;
  logic            lo_zero_q;

  logic            s1_hit_q;
  iuc_pkg::idx_t   s1_idx_q;
  iuc_pkg::id_t    s1_low_q;
  iuc_pkg::id_t    s1_high_q;

  logic            s2_hit_q;
  iuc_pkg::id_t    s2_diff_q;

  iuc_pkg::id_t    new_lo_q;
  iuc_pkg::id_t    new_hi_q;
  logic            found_q;
  iuc_pkg::idx_t   abs_idx_q;
  iuc_pkg::cnt_t   acc_q;

  logic left_ok;
  logic right_ok;
  logic hit;

  // touch or overlap: stored low <= high+1 and stored high >= low-1
  assign left_ok  = {1'b0, rd_data_i.lo} <= hi_p1_q;
  assign right_ok = lo_zero_q || (rd_data_i.hi >= lo_m1_q);
  assign hit      = p0_q.act && p0_q.vld && left_ok && right_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q     <= '0;
      s1_hit_q <= 1'b0;
      s2_hit_q <= 1'b0;
      found_q  <= 1'b0;
      acc_q    <= '0;
    end else begin
      p0_q     <= issue_i;
      s1_hit_q <= hit;
      s2_hit_q <= s1_hit_q;
      if (init_i) begin
        found_q <= 1'b0;
        acc_q   <= '0;
      end else begin
        if (hit && !found_q) begin
          found_q <= 1'b1;
        end
        if (s2_hit_q) begin
          acc_q <= acc_q + {1'b0, s2_diff_q} + iuc_pkg::cnt_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= p0_q.idx;
    s1_low_q  <= rd_data_i.lo;
    s1_high_q <= rd_data_i.hi;
    s2_diff_q <= s1_high_q - s1_low_q;
    if (init_i) begin
      hi_p1_q   <= {1'b0, item_i.range_high} + iuc_pkg::cnt_t'(1);
      lo_m1_q   <= item_i.range_low - iuc_pkg::id_t'(1);
      lo_zero_q <= (item_i.range_low == '0);
      new_lo_q  <= item_i.range_low;
      new_hi_q  <= item_i.range_high;
    end else begin
      if (hit && !found_q) begin
        abs_idx_q <= p0_q.idx;
      end
      if (s1_hit_q) begin
        if (s1_low_q < new_lo_q) begin
          new_lo_q <= s1_low_q;
        end
        if (s1_high_q > new_hi_q) begin
          new_hi_q <= s1_high_q;
        end
      end
    end
  end

  assign merge_o.hit     = s1_hit_q;
  assign merge_o.hit_idx = s1_idx_q;
  assign merge_o.found   = found_q;
  assign merge_o.abs_idx = abs_idx_q;
  assign merge_o.new_lo  = new_lo_q;
  assign merge_o.new_hi  = new_hi_q;
  assign merge_o.abs_sum = acc_q;

endmodule

/* hdl/interval_union_coverage.sv */
// top level of the interval union coverage block: scan sequencer, slot valid bits,
// interval table ram and result register
// depends on iuc_pkg, iuc_ram, iuc_merge and interval_union_coverage_macros.svh
//
// usage
//   input channel (in_valid_i, in_stall_o, in_word_i) carries one inclusive id interval
//   per word; output channel (out_valid_o, out_stall_i, out_word_o) returns one word
//   per input: ids newly covered, running total and status (ok, table full, empty)
//   a word moves on a rising edge with valid high and stall low
// sequence
//   a non-empty interval goes from acceptance to its result word through one ram read per
//   slot, a drain of the merge pipeline, then size, difference and total steps; the next
//   word is taken only once the block is back in idle with the result word registered;
//   an empty interval (low above high) skips the scan and goes straight to the total step
//   the single read port of the table ram makes the scan read the slots one at a time
// reset
//   all slot valid bits and the total clear at once; ram contents need no clearing
// stall
//   the result register holds its word while out_stall_i is high; the block still
//   takes and works on the next interval, and waits with it finished until the
//   register frees
`include "interval_union_coverage_macros.svh"
module interval_union_coverage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  iuc_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output iuc_pkg::out_word_t out_word_o
);

  localparam iuc_pkg::idx_t LAST_IDX = iuc_pkg::idx_t'(iuc_pkg::TABLE_ENTRIES - 1);
  localparam logic [iuc_pkg::DRAIN_W-1:0] DRAIN_LAST =
    iuc_pkg::DRAIN_W'(iuc_pkg::DRAIN_CYCLES - 1);

  iuc_pkg::state_e state_q, state_d;

  iuc_pkg::idx_t                     idx_q;
  logic [iuc_pkg::DRAIN_W-1:0]       drain_q;
  logic [iuc_pkg::TABLE_ENTRIES-1:0] valid_q;
  logic                              free_found_q;
  iuc_pkg::idx_t                     free_idx_q;
  iuc_pkg::id_t                      covered_q;
  iuc_pkg::cnt_t                     m_q;
  iuc_pkg::status_e                  status_q;
  iuc_pkg::id_t                      newly_q;
  logic                              out_valid_q;
  iuc_pkg::out_word_t                out_word_q;

  logic            accept;
  logic            in_empty;
  logic            out_free;
  logic            dest_ok;
  iuc_pkg::idx_t   dest;
  logic            wr_en;
  iuc_pkg::issue_t issue;
  iuc_pkg::merge_t mrg;
  iuc_pkg::entry_t rd_data;
  iuc_pkg::entry_t wr_data;
  iuc_pkg::cnt_t   diff;
  iuc_pkg::cnt_t   sum;
  iuc_pkg::id_t    total;

  // only idle takes a new interval
  assign in_stall_o = (state_q != iuc_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_empty   = in_word_i.range_low > in_word_i.range_high;
  assign out_free   = !out_valid_q || !out_stall_i;

  // scan issue: one slot per cycle, valid bit travels with the ram read
  assign issue.act = (state_q == iuc_pkg::S_SCAN);
  assign issue.vld = valid_q[idx_q];
  assign issue.idx = idx_q;

  // merged interval reuses the lowest absorbed slot, else the lowest free one
  assign dest_ok = mrg.found || free_found_q;
  assign dest    = mrg.found ? mrg.abs_idx : free_idx_q;
  assign wr_en   = (state_q == iuc_pkg::S_SPAN) && dest_ok;
  assign wr_data.lo = mrg.new_lo;
  assign wr_data.hi = mrg.new_hi;

  // merged size less absorbed sizes, never negative
  assign diff  = m_q - mrg.abs_sum;
  assign sum   = {1'b0, covered_q} + {1'b0, newly_q};
  assign total = sum[iuc_pkg::ID_W] ? '1 : sum[iuc_pkg::ID_W-1:0];

  iuc_ram #(
    .WIDTH ($bits(iuc_pkg::entry_t)),
    .DEPTH (iuc_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (dest),
    .wdata_i (wr_data),
    .re_i    (issue.act),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  iuc_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .init_i    (accept),
    .item_i    (in_word_i),
    .issue_i   (issue),
    .rd_data_i (rd_data),
    .merge_o   (mrg)
  );

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iuc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iuc_pkg::S_IDLE: begin
        if (accept) begin
          state_d = in_empty ? iuc_pkg::S_RESULT : iuc_pkg::S_SCAN;
        end
      end
      iuc_pkg::S_SCAN: begin
        if (idx_q == LAST_IDX) begin
          state_d = iuc_pkg::S_DRAIN;
        end
      end
      iuc_pkg::S_DRAIN: begin
        if (drain_q == DRAIN_LAST) begin
          state_d = iuc_pkg::S_SPAN;
        end
      end
      iuc_pkg::S_SPAN:   state_d = iuc_pkg::S_DIFF;
      iuc_pkg::S_DIFF:   state_d = iuc_pkg::S_RESULT;
      iuc_pkg::S_RESULT: begin
        if (out_free) begin
          state_d = iuc_pkg::S_IDLE;
        end
      end
      default: state_d = iuc_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      covered_q    <= '0;
      out_valid_q  <= 1'b0;
      free_found_q <= 1'b0;
      idx_q        <= '0;
      drain_q      <= '0;
    end else begin
      // absorbed slots drop out during the scan and drain, the merged one comes back at the end
      if (mrg.hit) begin
        valid_q[mrg.hit_idx] <= 1'b0;
      end
      if (wr_en) begin
        valid_q[dest] <= 1'b1;
      end
      if (accept) begin
        idx_q        <= '0;
        free_found_q <= 1'b0;
      end
      if (state_q == iuc_pkg::S_SCAN) begin
        idx_q   <= idx_q + iuc_pkg::idx_t'(1);
        drain_q <= '0;
        if (!valid_q[idx_q] && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (state_q == iuc_pkg::S_DRAIN) begin
        drain_q <= drain_q + iuc_pkg::DRAIN_W'(1);
      end
      if (state_q == iuc_pkg::S_RESULT && out_free) begin
        out_valid_q <= 1'b1;
        covered_q   <= total;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept && in_empty) begin
      status_q <= iuc_pkg::ST_EMPTY;
      newly_q  <= '0;
    end
    if (state_q == iuc_pkg::S_SCAN && !valid_q[idx_q] && !free_found_q) begin
      free_idx_q <= idx_q;
    end
    if (state_q == iuc_pkg::S_SPAN) begin
      m_q      <= {1'b0, mrg.new_hi - mrg.new_lo} + iuc_pkg::cnt_t'(1);
      status_q <= dest_ok ? iuc_pkg::ST_OK : iuc_pkg::ST_FULL;
    end
    if (state_q == iuc_pkg::S_DIFF) begin
      if (status_q != iuc_pkg::ST_OK) begin
        newly_q <= '0;
      end else begin
        newly_q <= diff[iuc_pkg::ID_W] ? '1 : diff[iuc_pkg::ID_W-1:0];
      end
    end
    if (state_q == iuc_pkg::S_RESULT && out_free) begin
      out_word_q.newly_covered <= newly_q;
      out_word_q.total_covered <= total;
      out_word_q.insert_status <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `IUC_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != iuc_pkg::S_IDLE,
                   "accepted word did not start work")
  `IUC_ASSERT(a_hit_only_in_scan,
              mrg.hit |-> (state_q == iuc_pkg::S_SCAN || state_q == iuc_pkg::S_DRAIN),
              "slot absorbed outside scan")
  `IUC_ASSERT(a_reject_adds_nothing,
              out_valid_o && out_word_o.insert_status != iuc_pkg::ST_OK
                |-> out_word_o.newly_covered == '0,
              "rejected word reports coverage")
  `IUC_ASSERT_NEXT(a_total_never_drops, state_q == iuc_pkg::S_RESULT && out_free,
                   covered_q >= $past(covered_q), "covered total decreased")

endmodule

/* dv/interval_union_coverage_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for interval_union_coverage: a directed table, random
// cluster traffic, a table-fill phase and a saturating close, scored by a coverage model
// depends on iuc_pkg and the interval_union_coverage rtl
module interval_union_coverage_tb;

  localparam iuc_pkg::id_t ID_MAX        = '1;
  // watchdog limit on cycles with no word moving on either channel
  localparam int unsigned WATCHDOG_LIMIT = 8 * iuc_pkg::TABLE_ENTRIES + 200;
  localparam int unsigned SETTLE_CYCLES  = iuc_pkg::TABLE_ENTRIES + 20;
  localparam int unsigned RANDOM_WORDS   = 560;
  localparam int unsigned CROWDED_WORDS  = 150;

  // shapes of generated intervals
  typedef enum int unsigned {
    SH_CLUSTER,  // short interval near one of a few centres, so merges pile up
    SH_WIDE,     // short interval at a random spot, every bit of both bounds moves
    SH_EMPTY,    // low above high
    SH_ANY,      // both bounds fully random, often huge or empty
    SH_ABOVE,    // starts right after a stored interval
    SH_BELOW,    // ends right before a stored interval
    SH_INSIDE    // single id inside a stored interval
  } shape_e;

  typedef struct {
    iuc_pkg::id_t       lo;
    iuc_pkg::id_t       hi;
    bit                 typed;
    iuc_pkg::out_word_t want;
  } row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  iuc_pkg::in_word_t  in_word_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  iuc_pkg::out_word_t out_word_o;

  interval_union_coverage dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  // opening table: typed rows are read straight off the rules (empty words and the
  // first single ids after reset), the rest are scored by the model
  row_t opening_rows [16] = '{
    '{64'd5,    64'd3,    1'b1, '{64'd0, 64'd0, iuc_pkg::ST_EMPTY}},
    '{ID_MAX,   64'd0,    1'b1, '{64'd0, 64'd0, iuc_pkg::ST_EMPTY}},
    '{64'd0,    64'd0,    1'b1, '{64'd1, 64'd1, iuc_pkg::ST_OK}},
    '{ID_MAX,   ID_MAX,   1'b1, '{64'd1, 64'd2, iuc_pkg::ST_OK}},
    // touches the interval at zero
    '{64'd1,    64'd1,    1'b0, '0},
    // touches the interval at the top id
    '{64'hFFFF_FFFF_FFFF_FFFD, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0},
    '{64'd100,  64'd200,  1'b0, '0},
    '{64'd202,  64'd300,  1'b0, '0},
    // fills the one-id hole and joins both neighbours
    '{64'd201,  64'd201,  1'b0, '0},
    // wholly inside, adds nothing
    '{64'd150,  64'd250,  1'b0, '0},
    '{64'd50,   64'd400,  1'b0, '0},
    '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0, '0},
    // adjacent across the top-bit boundary
    '{64'h7FFF_FFFF_FFFF_FFF0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
    // takes the lowest free slot
    '{64'd3,    64'd3,    1'b0, '0},
    // bridges two stored intervals into one
    '{64'd2,    64'd2,    1'b0, '0}
  };

  // closing table: the whole id space saturates the total, after which the
  // total is pinned at its maximum
  row_t closing_rows [3] = '{
    '{64'd0, ID_MAX, 1'b0, '0},
    '{64'd5, 64'd5,  1'b1, '{64'd0, ID_MAX, iuc_pkg::ST_OK}},
    '{64'd9, 64'd4,  1'b1, '{64'd0, ID_MAX, iuc_pkg::ST_EMPTY}}
  };

  // coverage model state
  iuc_pkg::id_t cov_lo   [iuc_pkg::TABLE_ENTRIES];
  iuc_pkg::id_t cov_hi   [iuc_pkg::TABLE_ENTRIES];
  bit           cov_used [iuc_pkg::TABLE_ENTRIES];
  iuc_pkg::id_t covered_ids = '0;

  iuc_pkg::out_word_t pending_results [$];
  int unsigned        mismatches    = 0;
  int unsigned        silent_cycles = 0;
  bit                 quiet         = 1'b0;  // no idling at all on either side
  bit                 idle_en       = 1'b1;  // idling allowed in this stretch

  // does [lo,hi] overlap or touch stored slot i
  function automatic bit links(iuc_pkg::id_t lo, iuc_pkg::id_t hi, int unsigned i);
    return cov_used[i] && ({1'b0, cov_lo[i]} <= {1'b0, hi} + 65'd1) &&
           ({1'b0, lo} <= {1'b0, cov_hi[i]} + 65'd1);
  endfunction

  // number of ids in [a,b], 65 bits wide so the full space fits
  function automatic iuc_pkg::cnt_t span_of(iuc_pkg::id_t a, iuc_pkg::id_t b);
    return {1'b0, b} - {1'b0, a} + iuc_pkg::cnt_t'(1);
  endfunction

  function automatic int unsigned free_slots();
    int unsigned n;
    n = 0;
    for (int i = 0; i < iuc_pkg::TABLE_ENTRIES; i++) n += cov_used[i] ? 0 : 1;
    return n;
  endfunction

  function automatic bit touches_any(iuc_pkg::id_t lo, iuc_pkg::id_t hi);
    for (int i = 0; i < iuc_pkg::TABLE_ENTRIES; i++) begin
      if (links(lo, hi, i)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // merge one interval into the table and work out the result word
  function automatic iuc_pkg::out_word_t cover_insert(iuc_pkg::id_t lo, iuc_pkg::id_t hi);
    iuc_pkg::out_word_t r;
    iuc_pkg::id_t       m_lo;
    iuc_pkg::id_t       m_hi;
    iuc_pkg::cnt_t      absorbed;
    iuc_pkg::cnt_t      gained;
    iuc_pkg::cnt_t      sum;
    int                 dest;
    int                 first_free;
    bit                 hit [iuc_pkg::TABLE_ENTRIES];
    r.newly_covered = '0;
    r.total_covered = covered_ids;
    r.insert_status = iuc_pkg::ST_EMPTY;
    if (lo > hi) return r;
    m_lo       = lo;
    m_hi       = hi;
    absorbed   = '0;
    dest       = -1;
    first_free = -1;
    for (int i = 0; i < iuc_pkg::TABLE_ENTRIES; i++) begin
      hit[i] = links(lo, hi, i);
      if (!cov_used[i] && first_free < 0) first_free = i;
      if (hit[i]) begin
        if (dest < 0) dest = i;
        if (cov_lo[i] < m_lo) m_lo = cov_lo[i];
        if (cov_hi[i] > m_hi) m_hi = cov_hi[i];
        absorbed += span_of(cov_lo[i], cov_hi[i]);
      end
    end
    // nothing absorbed: lowest free slot, or dropped when there is none
    if (dest < 0) dest = first_free;
    if (dest < 0) begin
      r.insert_status = iuc_pkg::ST_FULL;
      return r;
    end
    for (int i = 0; i < iuc_pkg::TABLE_ENTRIES; i++) begin
      if (hit[i]) cov_used[i] = 1'b0;
    end
    cov_lo[dest]   = m_lo;
    cov_hi[dest]   = m_hi;
    cov_used[dest] = 1'b1;
    gained = span_of(m_lo, m_hi) - absorbed;
    r.newly_covered = gained[iuc_pkg::ID_W] ? ID_MAX : gained[iuc_pkg::ID_W-1:0];
    sum = {1'b0, covered_ids} + {1'b0, r.newly_covered};
    covered_ids = sum[iuc_pkg::ID_W] ? ID_MAX : sum[iuc_pkg::ID_W-1:0];
    r.total_covered = covered_ids;
    r.insert_status = iuc_pkg::ST_OK;
    return r;
  endfunction

  function automatic bit pick_stored(output int unsigned slot);
    slot = 0;
    for (int t = 0; t < 4 * iuc_pkg::TABLE_ENTRIES; t++) begin
      slot = $urandom_range(0, iuc_pkg::TABLE_ENTRIES - 1);
      if (cov_used[slot]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic iuc_pkg::in_word_t draw_interval(shape_e shape, iuc_pkg::id_t centre);
    iuc_pkg::in_word_t w;
    int unsigned       slot;
    w.range_low  = centre + iuc_pkg::id_t'($urandom_range(0, 4000));
    w.range_high = w.range_low + iuc_pkg::id_t'($urandom_range(0, 40));
    // shapes that lean on the table fall back to a cluster word when it is empty
    if ((shape == SH_ABOVE || shape == SH_BELOW || shape == SH_INSIDE) &&
        !pick_stored(slot)) shape = SH_CLUSTER;
    case (shape)
      SH_WIDE: begin
        w.range_low  = {$urandom, $urandom};
        w.range_high = w.range_low + iuc_pkg::id_t'($urandom_range(0, 255));
      end
      SH_EMPTY: begin
        w.range_high = {$urandom, $urandom};
        w.range_low  = w.range_high + iuc_pkg::id_t'(1) +
                       iuc_pkg::id_t'($urandom_range(0, 1000));
      end
      SH_ANY: w = {$urandom, $urandom, $urandom, $urandom};
      SH_ABOVE: begin
        w.range_low  = cov_hi[slot] + iuc_pkg::id_t'(1);
        w.range_high = w.range_low + iuc_pkg::id_t'($urandom_range(0, 20));
      end
      SH_BELOW: begin
        w.range_high = cov_lo[slot] - iuc_pkg::id_t'(1);
        w.range_low  = w.range_high - iuc_pkg::id_t'($urandom_range(0, 20));
      end
      SH_INSIDE: begin
        w.range_low  = cov_lo[slot] + (cov_hi[slot] - cov_lo[slot]) / 2;
        w.range_high = w.range_low;
      end
      default: ;
    endcase
    return w;
  endfunction

  // present one word, hold it until taken, then score it and maybe idle
  task automatic offer(iuc_pkg::in_word_t w, iuc_pkg::out_word_t typed_want, bit typed);
    iuc_pkg::out_word_t model;
    bit                 took;
    bit                 ready;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    model = cover_insert(w.range_low, w.range_high);
    pending_results.push_back(typed ? typed_want : model);
    if (!quiet && idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      in_word_i  <= {$urandom, $urandom, $urandom, $urandom};
      // half the gaps land while the block is busy, half once it is ready again
      if ($urandom_range(0, 1) == 1) begin
        do begin
          @(negedge clk_i);
          ready = !in_stall_o;
          @(posedge clk_i);
        end while (!ready);
      end
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(string field, iuc_pkg::id_t got, iuc_pkg::id_t want);
    mismatches++;
    $display("mismatch at %0t: %s got %h want %h", $time, field, got, want);
  endtask

  // receiver: random stall bursts
  initial begin : out_idling
    int unsigned hold;
    forever begin
      @(posedge clk_i);
      if (!quiet && idle_en && $urandom_range(0, 15) == 0) begin
        out_stall_i <= 1'b1;
        hold = $urandom_range(1, 9);
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // scoreboard and watchdog, sampled mid-cycle so the edge order never matters
  always @(negedge clk_i) begin : scoring
    iuc_pkg::out_word_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) silent_cycles = 0;
      else silent_cycles++;
      if (silent_cycles >= WATCHDOG_LIMIT) begin
        $display("** interval_union_coverage: FAILED **");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("word with nothing pending, newly_covered",
                          out_word_o.newly_covered, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_word_o.newly_covered !== want.newly_covered)
            report_mismatch("newly_covered", out_word_o.newly_covered, want.newly_covered);
          if (out_word_o.total_covered !== want.total_covered)
            report_mismatch("total_covered", out_word_o.total_covered, want.total_covered);
          if (out_word_o.insert_status !== want.insert_status)
            report_mismatch("insert_status", iuc_pkg::id_t'(out_word_o.insert_status),
                            iuc_pkg::id_t'(want.insert_status));
        end
      end
    end
  end

  initial begin : stimulus
    iuc_pkg::id_t centres [4];
    iuc_pkg::id_t b;
    int unsigned  tries;
    shape_e       shape;
    int unsigned  roll;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_rows[i])
      offer({opening_rows[i].lo, opening_rows[i].hi}, opening_rows[i].want,
            opening_rows[i].typed);

    // mixed traffic, mostly clustered so intervals keep merging into shared slots
    foreach (centres[c]) centres[c] = {$urandom, $urandom};
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) idle_en = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 99);
      if (roll < 55)      shape = SH_CLUSTER;
      else if (roll < 68) shape = SH_WIDE;
      else if (roll < 76) shape = SH_EMPTY;
      else if (roll < 79) shape = SH_ANY;
      else if (roll < 88) shape = SH_ABOVE;
      else if (roll < 95) shape = SH_BELOW;
      else                shape = SH_INSIDE;
      offer(draw_interval(shape, centres[$urandom_range(0, 3)]), '0, 1'b0);
    end

    // fill every slot with isolated two-id intervals
    idle_en = 1'b1;
    for (int n = 0; n < 2 * iuc_pkg::TABLE_ENTRIES && free_slots() != 0; n++) begin
      tries = 0;
      do begin
        b = {$urandom, $urandom};
        tries++;
      end while (touches_any(b, b + iuc_pkg::id_t'(1)) && tries < 64);
      offer({b, b + 64'd1}, '0, 1'b0);
    end

    // table full: isolated words are dropped, merging ones still go in
    quiet = 1'b1;
    for (int n = 0; n < CROWDED_WORDS; n++) begin
      case ($urandom_range(0, 4))
        0: shape = SH_WIDE;
        1: shape = SH_ABOVE;
        2: shape = SH_BELOW;
        3: shape = SH_INSIDE;
        default: shape = SH_EMPTY;
      endcase
      offer(draw_interval(shape, '0), '0, 1'b0);
    end

    foreach (closing_rows[i])
      offer({closing_rows[i].lo, closing_rows[i].hi}, closing_rows[i].want,
            closing_rows[i].typed);
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** interval_union_coverage: PASSED **");
    end else begin
      $display("** interval_union_coverage: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/iuc_pkg.sv
hdl/iuc_ram.sv
hdl/iuc_merge.sv
hdl/interval_union_coverage.sv
dv/interval_union_coverage_tb.sv
